// ===== hdl/ppba_pkg.sv =====
// Shared constants, codes and types of the paged pool block allocator.
`default_nettype none
package ppba_pkg;

	// Pool geometry
	localparam int MAX_PAGES           = 16;
	localparam int MAX_BLOCKS_PER_PAGE = 256;
	localparam int BLOCK_HEADER_BYTES  = 8;
	localparam int PAGE_HEADER_BYTES   = 8;

	localparam int PAGE_W      = $clog2(MAX_PAGES);
	localparam int SLOT_W      = $clog2(MAX_BLOCKS_PER_PAGE);
	localparam int HANDLE_W    = 12;
	localparam int STORE_DEPTH = MAX_PAGES * MAX_BLOCKS_PER_PAGE;

	// Field and register widths
	localparam int CMD_W      = 2;
	localparam int ADDR_W     = 20;
	localparam int PCOUNT_W   = 5;
	localparam int BCOUNT_W   = 13;
	localparam int DSIZE_W    = 16;
	localparam int PSIZE_W    = 17;
	localparam int ALIGN_W    = 4;
	localparam int BBYTES_W   = 17;
	localparam int BIP_W      = 9;
	localparam int FRESH_W    = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	typedef logic [CMD_W-1:0]     cmd_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// Command codes
	localparam cmd_t CMD_ALLOC    = 2'd0;
	localparam cmd_t CMD_FREE     = 2'd1;
	localparam cmd_t CMD_FREE_ALL = 2'd2;
	localparam cmd_t CMD_NOP      = 2'd3;

	// Register indexes
	localparam cfg_idx_t REG_USER_BYTES = 2'd0;
	localparam cfg_idx_t REG_PAGE_BYTES = 2'd1;
	localparam cfg_idx_t REG_ALIGN_LOG2 = 2'd2;

	// Register reset values and the derived values that follow from them
	localparam int RST_USER_BYTES = 8;
	localparam int RST_PAGE_BYTES = 4096;
	localparam int RST_ALIGN_LOG2 = 3;
	localparam int RST_MINIMAL    = (RST_USER_BYTES > BLOCK_HEADER_BYTES) ?
		RST_USER_BYTES : BLOCK_HEADER_BYTES;
	localparam int RST_ALIGN      = 1 << RST_ALIGN_LOG2;
	localparam int RST_BBYTES     = ((RST_MINIMAL + RST_ALIGN - 1) / RST_ALIGN) * RST_ALIGN;
	localparam int RST_BIP_RAW    = (RST_PAGE_BYTES - PAGE_HEADER_BYTES) / RST_BBYTES;
	localparam int RST_BIP        = (RST_BIP_RAW > MAX_BLOCKS_PER_PAGE) ?
		MAX_BLOCKS_PER_PAGE : RST_BIP_RAW;

	// One quotient bit per cycle over the page size
	localparam int DIV_STEPS = PSIZE_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

endpackage
`default_nettype wire

// ===== hdl/ppba_if.sv =====
// Request and result channel interfaces of the paged pool block allocator.
`default_nettype none
interface ppba_req_if import ppba_pkg::*; ();
	logic                valid;
	logic                ready;
	cmd_t                command;
	logic [HANDLE_W-1:0] free_handle;

	modport source (output valid, output command, output free_handle, input ready);
	modport sink (input valid, input command, input free_handle, output ready);
endinterface

interface ppba_res_if import ppba_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ADDR_W-1:0]   block_address;
	logic [HANDLE_W-1:0] block_handle;
	logic                out_of_memory;
	logic [PCOUNT_W-1:0] page_count;
	logic [BCOUNT_W-1:0] block_count;
	logic [BCOUNT_W-1:0] free_count;

	modport source (output valid, output block_address, output block_handle,
		output out_of_memory, output page_count, output block_count,
		output free_count, input ready);
	modport sink (input valid, input block_address, input block_handle,
		input out_of_memory, input page_count, input block_count,
		input free_count, output ready);
endinterface
`default_nettype wire

// ===== hdl/paged_pool_block_allocator_top.sv =====
// Top level of the paged pool block allocator.
//
// Hands out fixed-size blocks carved from up to 16 pages. Freed blocks sit on
// a LIFO stack threaded through the link store RAM (one entry per handle);
// when the stack is empty the next unused block of the newest page is taken,
// and when that page is used up a new page is opened. In the accept cycle
// of a request beat the link store is read at the stack head; then, in the
// execute state, the pop, push or page opening is applied, the link store
// is written on a free and the result register is loaded. The execute state
// holds while an earlier result beat still waits in the result register, and
// no new request beat is accepted until the last one has been executed. A
// write to any of the three configuration registers empties the pool and
// recomputes the block size and the blocks per page; the division runs one
// quotient bit per cycle, and while the sequencer passes through the prepare,
// divide and latch states no request beat is accepted. The link store is
// never cleared: its read data are only used at handles pushed by a free.
`default_nettype none
module paged_pool_block_allocator_top import ppba_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	ppba_req_if.sink              req,
	ppba_res_if.source            res,
	input  logic                  cfg_we,
	input  cfg_idx_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EXEC  = 3'd1;
	localparam logic [2:0] ST_PREP  = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_LATCH = 3'd4;

	logic [2:0] state_q;

	// Configuration and derived geometry
	logic [DSIZE_W-1:0]  user_bytes_q;
	logic [PSIZE_W-1:0]  page_bytes_q;
	logic [ALIGN_W-1:0]  align_q;
	logic [BBYTES_W-1:0] bbytes_q;
	logic [BIP_W-1:0]    bip_q;

	// Pool state
	logic [HANDLE_W-1:0] head_q;
	logic                nonempty_q;
	logic [FRESH_W-1:0]  fresh_q;
	logic [PCOUNT_W-1:0] pages_q;
	logic [BCOUNT_W-1:0] total_q;
	logic [BCOUNT_W-1:0] free_q;

	// Accepted request
	cmd_t                cmd_s1;
	logic [HANDLE_W-1:0] handle_s1;

	// Divider
	logic [PSIZE_W-1:0]   div_rem_q;
	logic [PSIZE_W-1:0]   div_quo_q;
	logic [PSIZE_W-1:0]   div_dvd_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	// Result register
	logic                res_valid_q;
	logic [ADDR_W-1:0]   res_addr_q;
	logic [HANDLE_W-1:0] res_handle_q;
	logic                res_oom_q;
	logic [PCOUNT_W-1:0] res_pages_q;
	logic [BCOUNT_W-1:0] res_total_q;
	logic [BCOUNT_W-1:0] res_free_q;

	// Link store
	logic                link_we;
	logic [HANDLE_W-1:0] link_rdata;

	logic req_fire;
	logic exec_fire;
	logic cfg_hit;

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign exec_fire = (state_q == ST_EXEC) && (!res_valid_q || res.ready);
	assign cfg_hit   = cfg_we && ((cfg_index == REG_USER_BYTES) ||
		(cfg_index == REG_PAGE_BYTES) || (cfg_index == REG_ALIGN_LOG2));

	assign res.valid         = res_valid_q;
	assign res.block_address = res_addr_q;
	assign res.block_handle  = res_handle_q;
	assign res.out_of_memory = res_oom_q;
	assign res.page_count    = res_pages_q;
	assign res.block_count   = res_total_q;
	assign res.free_count    = res_free_q;

	// Block size: max(data size, block header) rounded up to the alignment
	logic [DSIZE_W-1:0]  minimal;
	logic [BBYTES_W-1:0] align_mask;
	logic [BBYTES_W-1:0] rounded;
	logic [BBYTES_W-1:0] bbytes_new;

	always_comb begin
		minimal    = (user_bytes_q > DSIZE_W'(BLOCK_HEADER_BYTES)) ?
			user_bytes_q : DSIZE_W'(BLOCK_HEADER_BYTES);
		align_mask = (BBYTES_W'(1) << align_q) - BBYTES_W'(1);
		rounded    = {1'b0, minimal} + align_mask;
		bbytes_new = rounded & ~align_mask;
	end

	// One restoring-division step: remainder gains the next dividend bit
	logic [PSIZE_W+1:0] div_trial;
	logic               div_ge;
	logic [PSIZE_W-1:0] div_rem_nx;
	logic               page_small;

	always_comb begin
		div_trial  = {1'b0, div_rem_q, div_dvd_q[PSIZE_W-1]} - {2'b00, bbytes_q};
		div_ge     = !div_trial[PSIZE_W+1];
		div_rem_nx = div_ge ? div_trial[PSIZE_W-1:0] :
			{div_rem_q[PSIZE_W-2:0], div_dvd_q[PSIZE_W-1]};
		page_small = (page_bytes_q <= PSIZE_W'(PAGE_HEADER_BYTES));
	end

	// Request execution
	logic [FRESH_W-1:0]  fresh_left;
	logic [PAGE_W-1:0]   newest_page;
	logic [HANDLE_W-1:0] head_nx;
	logic                nonempty_nx;
	logic [FRESH_W-1:0]  fresh_nx;
	logic [PCOUNT_W-1:0] pages_nx;
	logic [BCOUNT_W-1:0] total_nx;
	logic [BCOUNT_W-1:0] free_nx;
	logic                got;
	logic                oom;
	logic [HANDLE_W-1:0] out_handle;
	logic [PAGE_W-1:0]   a_page;
	logic [SLOT_W-1:0]   a_slot;
	logic [PAGE_W+PSIZE_W-1:0]   prod_page;
	logic [SLOT_W+BBYTES_W-1:0]  prod_slot;
	logic [ADDR_W-1:0]   addr_sum;
	logic [PAGE_W-1:0]   f_page;
	logic [SLOT_W-1:0]   f_slot;
	logic                free_ok;

	always_comb begin
		fresh_left  = ((pages_q == '0) || (fresh_q >= bip_q)) ? '0 : (bip_q - fresh_q);
		newest_page = pages_q[PAGE_W-1:0] - PAGE_W'(1);
		head_nx     = head_q;
		nonempty_nx = nonempty_q;
		fresh_nx    = fresh_q;
		pages_nx    = pages_q;
		total_nx    = total_q;
		free_nx     = free_q;
		got         = 1'b0;
		oom         = 1'b0;
		out_handle  = '0;
		link_we     = 1'b0;

		f_page  = handle_s1[HANDLE_W-1:SLOT_W];
		f_slot  = handle_s1[SLOT_W-1:0];
		free_ok = ({1'b0, f_page} < pages_q) && ({1'b0, f_slot} < bip_q) &&
			!((({1'b0, f_page} + PCOUNT_W'(1)) == pages_q) && ({1'b0, f_slot} >= fresh_q)) &&
			(free_q < total_q);

		unique case (cmd_s1)
			CMD_ALLOC: begin
				if (nonempty_q) begin
					// pop: the link read at the head is the new head
					got         = 1'b1;
					out_handle  = head_q;
					head_nx     = link_rdata;
					free_nx     = free_q - BCOUNT_W'(1);
					nonempty_nx = (free_nx > BCOUNT_W'(fresh_left));
				end else if (fresh_left != '0) begin
					got        = 1'b1;
					out_handle = {newest_page, fresh_q[SLOT_W-1:0]};
					fresh_nx   = fresh_q + FRESH_W'(1);
					free_nx    = free_q - BCOUNT_W'(1);
				end else if ((bip_q == '0) || (pages_q >= PCOUNT_W'(MAX_PAGES))) begin
					oom = 1'b1;
				end else begin
					// open a new page and take its first block
					got        = 1'b1;
					out_handle = {pages_q[PAGE_W-1:0], SLOT_W'(0)};
					pages_nx   = pages_q + PCOUNT_W'(1);
					total_nx   = total_q + BCOUNT_W'(bip_q);
					free_nx    = free_q + BCOUNT_W'(bip_q) - BCOUNT_W'(1);
					fresh_nx   = FRESH_W'(1);
				end
			end
			CMD_FREE: begin
				if (free_ok) begin
					link_we     = exec_fire;
					head_nx     = handle_s1;
					nonempty_nx = 1'b1;
					free_nx     = free_q + BCOUNT_W'(1);
				end
			end
			CMD_FREE_ALL: begin
				head_nx     = '0;
				nonempty_nx = 1'b0;
				fresh_nx    = '0;
				pages_nx    = '0;
				total_nx    = '0;
				free_nx     = '0;
			end
			default: begin
			end
		endcase

		a_page    = out_handle[HANDLE_W-1:SLOT_W];
		a_slot    = out_handle[SLOT_W-1:0];
		prod_page = (PAGE_W+PSIZE_W)'(a_page) * (PAGE_W+PSIZE_W)'(page_bytes_q);
		prod_slot = (SLOT_W+BBYTES_W)'(a_slot) * (SLOT_W+BBYTES_W)'(bbytes_q);
		addr_sum  = prod_page[ADDR_W-1:0] + prod_slot[ADDR_W-1:0] +
			ADDR_W'(PAGE_HEADER_BYTES);
	end

	ppba_ram #(
		.WIDTH (HANDLE_W),
		.DEPTH (STORE_DEPTH)
	) u_link_store (
		.clk   (clk),
		.we    (link_we),
		.waddr (handle_s1),
		.wdata (head_q),
		.raddr (head_q),
		.rdata (link_rdata)
	);

	// Control and pool state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			user_bytes_q <= DSIZE_W'(RST_USER_BYTES);
			page_bytes_q <= PSIZE_W'(RST_PAGE_BYTES);
			align_q      <= ALIGN_W'(RST_ALIGN_LOG2);
			bbytes_q     <= BBYTES_W'(RST_BBYTES);
			bip_q        <= BIP_W'(RST_BIP);
			head_q       <= '0;
			nonempty_q   <= 1'b0;
			fresh_q      <= '0;
			pages_q      <= '0;
			total_q      <= '0;
			free_q       <= '0;
			div_cnt_q    <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			// drop the result beat once taken, load a new one on execution
			if (exec_fire) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end

			if (cfg_hit) begin
				// latch the register, empty the pool, restart the geometry
				unique case (cfg_index)
					REG_USER_BYTES: user_bytes_q <= cfg_data[DSIZE_W-1:0];
					REG_PAGE_BYTES: page_bytes_q <= cfg_data[PSIZE_W-1:0];
					REG_ALIGN_LOG2: align_q      <= cfg_data[ALIGN_W-1:0];
					default: begin
					end
				endcase
				head_q     <= '0;
				nonempty_q <= 1'b0;
				fresh_q    <= '0;
				pages_q    <= '0;
				total_q    <= '0;
				free_q     <= '0;
				state_q    <= ST_PREP;
			end else begin
				unique case (state_q)
					ST_IDLE: begin
						if (req_fire) begin
							state_q <= ST_EXEC;
						end
					end
					ST_EXEC: begin
						if (exec_fire) begin
							head_q     <= head_nx;
							nonempty_q <= nonempty_nx;
							fresh_q    <= fresh_nx;
							pages_q    <= pages_nx;
							total_q    <= total_nx;
							free_q     <= free_nx;
							state_q    <= ST_IDLE;
						end
					end
					ST_PREP: begin
						bbytes_q  <= bbytes_new;
						div_cnt_q <= DIV_CNT_W'(DIV_STEPS);
						state_q   <= ST_DIV;
					end
					ST_DIV: begin
						div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
						if (div_cnt_q == DIV_CNT_W'(1)) begin
							state_q <= ST_LATCH;
						end
					end
					ST_LATCH: begin
						// cap at a full page of handles; no room past the header
						if (page_small) begin
							bip_q <= '0;
						end else if (div_quo_q > PSIZE_W'(MAX_BLOCKS_PER_PAGE)) begin
							bip_q <= BIP_W'(MAX_BLOCKS_PER_PAGE);
						end else begin
							bip_q <= div_quo_q[BIP_W-1:0];
						end
						state_q <= ST_IDLE;
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (req_fire) begin
			cmd_s1    <= req.command;
			handle_s1 <= req.free_handle;
		end
		if (state_q == ST_PREP) begin
			div_rem_q <= '0;
			div_quo_q <= '0;
			div_dvd_q <= page_bytes_q - PSIZE_W'(PAGE_HEADER_BYTES);
		end else if (state_q == ST_DIV) begin
			div_rem_q <= div_rem_nx;
			div_quo_q <= {div_quo_q[PSIZE_W-2:0], div_ge};
			div_dvd_q <= {div_dvd_q[PSIZE_W-2:0], 1'b0};
		end
		if (exec_fire) begin
			res_addr_q   <= got ? addr_sum : '0;
			res_handle_q <= out_handle;
			res_oom_q    <= oom;
			res_pages_q  <= pages_nx;
			res_total_q  <= total_nx;
			res_free_q   <= free_nx;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/ppba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ppba_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire
